// ===== rtl/cbh_pkg.sv =====
// Shared types, constants and a helper function for the cancellable barrier home block.
package cbh_pkg;

    // Queue depth and derived widths.
    localparam int NODE_COUNT = 32;
    localparam int QIDX_W     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int CNT_W      = 6;
    localparam int NODE_W     = 5;
    localparam int RESULT_CAP = 32;
    localparam int MAX_PART   = (NODE_COUNT < RESULT_CAP) ? NODE_COUNT : RESULT_CAP;

    localparam logic [CNT_W-1:0] MAX_PART_C = CNT_W'(MAX_PART);
    localparam logic [CNT_W-1:0] ONE_PART_C = CNT_W'(1);

    // Request codes.
    typedef enum logic {
        ACT_ENTER  = 1'b0,
        ACT_CANCEL = 1'b1
    } action_t;

    // One request transfer.
    typedef struct packed {
        action_t           action;
        logic [NODE_W-1:0] requester;
    } in_item_t;

    // One release or cancel message.
    typedef struct packed {
        logic [NODE_W-1:0] target_node;
        logic              done_flag;
        logic              last_of_run;
    } out_item_t;

    // Zero counts as one, and the count is capped at the queue size and the run limit.
    function automatic logic [CNT_W-1:0] eff_part(input logic [CNT_W-1:0] p);
        logic [CNT_W-1:0] e;
        e = p;
        if (e == '0) begin
            e = ONE_PART_C;
        end
        if (e > MAX_PART_C) begin
            e = MAX_PART_C;
        end
        return e;
    endfunction

endpackage

// ===== rtl/cbh_waiter_ram.sv =====
// Waiter queue memory: one write port and one registered read port.
module cbh_waiter_ram
    import cbh_pkg::*;
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [QIDX_W-1:0] wr_addr,
    input  logic [NODE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [QIDX_W-1:0] rd_addr,
    output logic [NODE_W-1:0] rd_data
);

    logic [NODE_W-1:0] mem [NODE_COUNT];
    logic [NODE_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/cancellable_barrier_home_top.sv =====
// Top level of the cancellable barrier home: request handling, queue drain and output register.
//
// An enter request that does not complete the barrier is taken without a stall: the node is
// written into the waiter memory and nothing is sent. An enter that completes the barrier,
// or a cancel with N nodes waiting, starts a run that sends the N waiters oldest first, one
// message per cycle while the output is not stalled, set by the single read port of the
// waiter memory; a release then sends the arriving node last. The input stays stalled from
// the request transfer until the run is over: through the drain and, on a release, through
// the tail state that sends the arriving node (the only state when no node waits). No
// request is taken until the last message of the run has been handed to the output register.
// A cancel with no waiters is taken without a stall and sends nothing. There is no clearing
// pass after reset; the participants register may be written at any time the block is idle.
module cancellable_barrier_home_top
    import cbh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_item_t        out_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DRAIN,
        S_TAIL
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  part_reg, part_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [CNT_W-1:0]  iss_reg, iss_next;
    logic              done_reg, done_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              rd_last_reg, rd_last_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic              in_take;
    logic              out_free;
    logic              out_load_mem;
    logic              issue;
    logic              completes;
    logic              wr_en;
    logic [NODE_W-1:0] rd_data;

    // Waiter queue storage.
    cbh_waiter_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[QIDX_W-1:0]),
        .wr_data (in_data.requester),
        .rd_en   (issue),
        .rd_addr (iss_reg[QIDX_W-1:0]),
        .rd_data (rd_data)
    );

    // Handshake and drain control terms.
    assign in_take      = in_valid && (state_reg == S_IDLE);
    assign out_free     = !out_valid_reg || !out_stall;
    assign out_load_mem = rd_valid_reg && out_free;
    assign issue        = (state_reg == S_DRAIN) && (iss_reg != len_reg)
                          && (!rd_valid_reg || out_load_mem);
    assign completes    = ({1'b0, count_reg} + (CNT_W+1)'(1))
                          >= {1'b0, eff_part(part_reg)};
    assign wr_en        = in_take && (in_data.action == ACT_ENTER) && !completes;

    // Next-state logic for the sequencer, the read tracking and the output register.
    always_comb
    begin
        state_next     = state_reg;
        part_next      = cfg_wr_en ? cfg_wr_data : part_reg;
        count_next     = count_reg;
        len_next       = len_reg;
        iss_next       = iss_reg;
        done_next      = done_reg;
        node_next      = node_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        // Memory read tracking during a drain.
        rd_valid_next = issue || (rd_valid_reg && !out_load_mem);
        rd_last_next  = rd_last_reg;
        if (issue)
        begin
            iss_next     = iss_reg + CNT_W'(1);
            rd_last_next = !done_reg && ((iss_reg + CNT_W'(1)) == len_reg);
        end

        // Queued waiter moves into the output register.
        if (out_load_mem)
        begin
            out_valid_next            = 1'b1;
            out_data_next.target_node = rd_data;
            out_data_next.done_flag   = done_reg;
            out_data_next.last_of_run = rd_last_reg;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (in_data.action == ACT_ENTER)
                    begin
                        if (!completes)
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            len_next   = count_reg;
                            count_next = '0;
                            iss_next   = '0;
                            done_next  = 1'b1;
                            node_next  = in_data.requester;
                            state_next = (count_reg == '0) ? S_TAIL : S_DRAIN;
                        end
                    end
                    else if (count_reg != '0)
                    begin
                        len_next   = count_reg;
                        count_next = '0;
                        iss_next   = '0;
                        done_next  = 1'b0;
                        state_next = S_DRAIN;
                    end
                end
            end
            S_DRAIN:
            begin
                if ((iss_reg == len_reg) && !rd_valid_reg)
                begin
                    state_next = done_reg ? S_TAIL : S_IDLE;
                end
            end
            S_TAIL:
            begin
                // The arriving node closes a normal release.
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.target_node = node_reg;
                    out_data_next.done_flag   = 1'b1;
                    out_data_next.last_of_run = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            part_reg      <= ONE_PART_C;
            count_reg     <= '0;
            len_reg       <= '0;
            iss_reg       <= '0;
            done_reg      <= 1'b0;
            node_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            part_reg      <= part_next;
            count_reg     <= count_next;
            len_reg       <= len_next;
            iss_reg       <= iss_next;
            done_reg      <= done_next;
            node_reg      <= node_next;
            rd_valid_reg  <= rd_valid_next;
            rd_last_reg   <= rd_last_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/cbh_checker.sv =====
// Port-level checker for the cancellable barrier home, bound to the top level.
module cbh_checker
    import cbh_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             cfg_wr_en,
    input logic             in_valid,
    input logic             in_stall,
    input in_item_t         in_data,
    input logic             out_valid,
    input logic             out_stall,
    input out_item_t        out_data
);

    // A stalled message holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output message changed");

    // A run is not finished while its last message is still to come: either requests are
    // still held off or the next message of the run is already waiting.
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.last_of_run |=> in_stall || out_valid)
        else $error("message run ended without its last message");

    // Messages come only from a run, during which requests are held off.
    a_out_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("message appeared without a run in progress");

    // A stalled request holds until it is taken.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("stalled request changed");

    // The participants register is written only while the block is idle and no request is offered.
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |-> !in_valid && !in_stall)
        else $error("participants written while a request was in flight");

endmodule

bind cancellable_barrier_home_top cbh_checker u_cbh_checker (.*);

// ===== tb/sv/cancellable_barrier_home_checker.sv =====
`timescale 1ns / 100ps
// Checker for the cancellable barrier home: predicts every release and cancel message and compares.
module cancellable_barrier_home_checker
    import cbh_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    input  logic             in_stall,
    input  in_item_t         in_data,
    input  logic             out_valid,
    input  logic             out_stall,
    input  out_item_t        out_data,
    output int               fail_count,
    output int               msgs_pending
);

    // Predicted copy of the participants register and the waiter FIFO.
    logic [CNT_W-1:0]  part_reg;
    logic [NODE_W-1:0] waiters_q[$];
    out_item_t         msgs_due_q[$];
    int                errors;

    // Arrival count at which the barrier opens: zero means one, and the queue size caps it.
    function automatic int unsigned release_at();
        int unsigned p;
        p = 32'(part_reg);
        if (p == 0) begin
            p = 1;
        end
        if (p > MAX_PART) begin
            p = MAX_PART;
        end
        return p;
    endfunction

    // Every queued node gets one message, oldest first.
    task automatic flush_waiters(input logic done);
        out_item_t m;
        while (waiters_q.size() > 0) begin
            m.target_node = waiters_q.pop_front();
            m.done_flag   = done;
            m.last_of_run = 1'b0;
            msgs_due_q.push_back(m);
        end
    endtask

    // Work out the messages that one accepted request causes.
    task automatic take_request(input in_item_t req);
        out_item_t m;
        if (req.action == ACT_ENTER) begin
            if (waiters_q.size() + 1 >= release_at()) begin
                flush_waiters(1'b1);
                m.target_node = req.requester;
                m.done_flag   = 1'b1;
                m.last_of_run = 1'b1;
                msgs_due_q.push_back(m);
            end
            else begin
                waiters_q.push_back(req.requester);
            end
        end
        else if (waiters_q.size() > 0) begin
            // A cancel with nobody waiting sends nothing.
            flush_waiters(1'b0);
            msgs_due_q[msgs_due_q.size() - 1].last_of_run = 1'b1;
        end
    endtask

    // Compare one message transfer with the oldest prediction.
    task automatic check_msg(input out_item_t got);
        out_item_t want;
        if (msgs_due_q.size() == 0) begin
            if (errors < 10) begin
                $display("ERROR: unexpected message node=%0d done=%0b last=%0b",
                         got.target_node, got.done_flag, got.last_of_run);
            end
            errors++;
        end
        else begin
            want = msgs_due_q.pop_front();
            if (got.target_node !== want.target_node || got.done_flag !== want.done_flag ||
                got.last_of_run !== want.last_of_run) begin
                if (errors < 10) begin
                    $display({"ERROR: message mismatch: expected node=%0d done=%0b last=%0b,",
                              " got node=%0d done=%0b last=%0b"},
                             want.target_node, want.done_flag, want.last_of_run,
                             got.target_node, got.done_flag, got.last_of_run);
                end
                errors++;
            end
        end
    endtask

    // Watch both channels and the register port at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg = ONE_PART_C;
            waiters_q.delete();
            msgs_due_q.delete();
            errors = 0;
            fail_count   <= 0;
            msgs_pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                part_reg = cfg_wr_data;
            end
            if (out_valid && !out_stall)
            begin
                check_msg(out_data);
            end
            if (in_valid && !in_stall)
            begin
                take_request(in_data);
            end
            fail_count   <= errors;
            msgs_pending <= msgs_due_q.size();
        end
    end

endmodule

// ===== tb/sv/cancellable_barrier_home_top_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the cancellable barrier home: drives requests and writes, gives the verdict.
module cancellable_barrier_home_top_tb;
    import cbh_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CNT_W-1:0] cfg_wr_data;
    logic             in_valid;
    logic             in_stall;
    in_item_t         in_data;
    logic             out_valid;
    logic             out_stall;
    out_item_t        out_data;

    int               fail_count;
    int               msgs_pending;

    // Stimulus controls, each written by the main process only.
    int               snd_idle_pct;
    int               rcv_idle_pct;
    int               hold_requests;
    int               items_sent;
    logic [CNT_W-1:0] cur_part;

    // Receiver-side bookkeeping for the long hold-off.
    int               holds_served;
    int               hold_left;

    cancellable_barrier_home_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    cancellable_barrier_home_checker msg_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .fail_count   (fail_count),
        .msgs_pending (msgs_pending)
    );

    // 10 ns clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Offer one request, with random gaps first, and hold it until the transfer.
    task automatic send_req(input action_t act, input logic [NODE_W-1:0] node);
        @(negedge clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{action: act, requester: node};
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // Stop offering and wait until every predicted message has gone out.
    task automatic wait_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
        while (msgs_pending != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the participants register; only called while the block is idle.
    task automatic set_participants(input logic [CNT_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cur_part = value;
    endtask

    // A run of enters from random nodes, optionally closed by a cancel.
    task automatic run_barrier(input int span, input bit end_cancel);
        int i;
        for (i = 0; i < span; i++) begin
            send_req(ACT_ENTER, NODE_W'($urandom_range(31)));
        end
        if (end_cancel) begin
            send_req(ACT_CANCEL, NODE_W'($urandom_range(31)));
        end
    endtask

    // Mostly complete barriers at small sizes, with broken runs and odd settings mixed in.
    task automatic random_phase(input int count);
        int stop_at;
        int lim;
        int r;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 40) begin
                r = $urandom_range(99);
                wait_quiet();
                if (r < 75) begin
                    set_participants(CNT_W'($urandom_range(6, 1)));
                end
                else if (r < 85) begin
                    set_participants('0);
                end
                else if (r < 93) begin
                    set_participants(CNT_W'($urandom_range(12, 7)));
                end
                else begin
                    set_participants(CNT_W'($urandom_range(63, 33)));
                end
            end
            lim = (cur_part == 0) ? 1 : ((cur_part > MAX_PART) ? MAX_PART : int'(cur_part));
            if (lim > 12) begin
                run_barrier($urandom_range(4, 1), 1'b1);
            end
            else if ($urandom_range(99) < 85) begin
                run_barrier(lim, $urandom_range(99) < 20);
            end
            else begin
                run_barrier($urandom_range(lim + 1), $urandom_range(1) == 1);
            end
        end
    endtask

    // Receiver: random stalls, and a long hold-off whenever one is requested.
    initial
    begin
        out_stall    = 1'b0;
        holds_served = 0;
        hold_left    = 0;
        forever begin
            @(negedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < rcv_idle_pct);
            end
        end
    end

    // Run limit.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Main stimulus.
    initial
    begin
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        rst_n         = 1'b0;
        snd_idle_pct  = 10;
        rcv_idle_pct  = 86;
        hold_requests = 0;
        items_sent    = 0;
        cur_part      = ONE_PART_C;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // With one participant after reset, every enter releases at once.
        send_req(ACT_ENTER, 5'd0);
        send_req(ACT_ENTER, 5'd31);
        // Cancels with nobody waiting send nothing.
        send_req(ACT_CANCEL, 5'd31);
        send_req(ACT_CANCEL, 5'd0);
        // Zero participants behaves as one.
        wait_quiet();
        set_participants('0);
        send_req(ACT_ENTER, 5'd5);
        // Three participants, with a node entering twice.
        wait_quiet();
        set_participants(CNT_W'(3));
        send_req(ACT_ENTER, 5'd1);
        send_req(ACT_ENTER, 5'd1);
        send_req(ACT_ENTER, 5'd2);
        // Cancel with two waiters.
        send_req(ACT_ENTER, 5'd7);
        send_req(ACT_ENTER, 5'd9);
        send_req(ACT_CANCEL, 5'd0);
        // Participants lowered while nodes wait: the next enter releases all of them.
        send_req(ACT_ENTER, 5'd4);
        send_req(ACT_ENTER, 5'd6);
        wait_quiet();
        set_participants(CNT_W'(2));
        send_req(ACT_ENTER, 5'd8);
        // Oversized settings are capped; cancel those barriers part way.
        wait_quiet();
        set_participants('1);
        send_req(ACT_ENTER, 5'd10);
        send_req(ACT_ENTER, 5'd21);
        send_req(ACT_ENTER, 5'd0);
        send_req(ACT_CANCEL, 5'd31);
        wait_quiet();
        set_participants(CNT_W'(33));
        send_req(ACT_ENTER, 5'd3);
        send_req(ACT_CANCEL, 5'd3);

        // Sender rarely idle, receiver mostly stalled.
        random_phase(60);

        // Long receiver hold-off while releases keep coming, so the input backs up.
        wait_quiet();
        set_participants(CNT_W'(3));
        hold_requests++;
        run_barrier(9, 1'b0);

        // Sender mostly idle, receiver rarely stalled.
        snd_idle_pct = 86;
        rcv_idle_pct = 10;
        random_phase(70);

        // No idling: a full-size release, then more random traffic.
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        wait_quiet();
        set_participants(CNT_W'(MAX_PART));
        run_barrier(MAX_PART, 1'b0);
        random_phase(50);

        wait_quiet();
        if (fail_count == 0 && msgs_pending == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cbh_pkg.sv
rtl/cbh_waiter_ram.sv
rtl/cancellable_barrier_home_top.sv
rtl/cbh_checker.sv
tb/sv/cancellable_barrier_home_checker.sv
tb/sv/cancellable_barrier_home_top_tb.sv
